>>> design/isp_pkg.sv
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types and constants for the serial ISP programmer: item and result
// structs, command codes, frame opcodes and configuration register indexes.
// ----------------------------------------------------------------------------
package isp_pkg;

	// command codes
	localparam logic [2:0] CMD_ENABLE    = 3'd0;
	localparam logic [2:0] CMD_ERASE     = 3'd1;
	localparam logic [2:0] CMD_READ_CODE = 3'd2;
	localparam logic [2:0] CMD_WRITE_CODE = 3'd3;
	localparam logic [2:0] CMD_WRITE_LOCK = 3'd4;
	localparam logic [2:0] CMD_READ_LOCK = 3'd5;
	localparam logic [2:0] CMD_READ_SIG  = 3'd6;

	// item kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// frame bytes
	localparam logic [7:0] OP_PREFIX     = 8'hAC;
	localparam logic [7:0] OP_ENABLE     = 8'h53;
	localparam logic [7:0] OP_ERASE      = 8'h9F;
	localparam logic [7:0] OP_READ_CODE  = 8'h20;
	localparam logic [7:0] OP_WRITE_CODE = 8'h40;
	localparam logic [7:0] OP_READ_LOCK  = 8'h24;
	localparam logic [7:0] OP_READ_SIG   = 8'h28;
	localparam logic [7:0] FILLER        = 8'hAA;

	localparam int FRAME_W     = 32;
	localparam int BITS_W      = 6;
	localparam int WAIT_W      = 20;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 20;

	// configuration register indexes and reset values
	localparam logic [CFG_INDEX_W-1:0] CFG_ERASE_WAIT = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_RST   = 4'd1;
	localparam logic [WAIT_W-1:0]      ERASE_WAIT_RST = 20'd520;

	typedef struct packed {
		logic       kind;
		logic [2:0] command;
		logic [7:0] addr_high;
		logic [7:0] addr_low;
		logic [7:0] data_byte;
		logic       miso;
	} isp_in_t;

	typedef struct packed {
		logic       sck;
		logic       mosi;
		logic       rst_res;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       start_rejected;
	} isp_out_t;

endpackage

>>> design/isp_frame_build.sv
// ----------------------------------------------------------------------------
// isp_frame_build
// Builds the four-byte programming frame for a start item and flags command
// codes that have no frame.
// ----------------------------------------------------------------------------
module isp_frame_build import isp_pkg::*; (
	input  logic [2:0]         command,
	input  logic [7:0]         addr_high,
	input  logic [7:0]         addr_low,
	input  logic [7:0]         data_byte,
	output logic [FRAME_W-1:0] frame,
	output logic               frame_ok
);

	always_comb begin
		frame_ok = 1'b1;
		case (command)
			CMD_ENABLE:     frame = {OP_PREFIX, OP_ENABLE, FILLER, FILLER};
			CMD_ERASE:      frame = {OP_PREFIX, OP_ERASE, FILLER, FILLER};
			CMD_READ_CODE:  frame = {OP_READ_CODE, addr_high, addr_low, FILLER};
			CMD_WRITE_CODE: frame = {OP_WRITE_CODE, addr_high, addr_low, data_byte};
			CMD_WRITE_LOCK: frame = {OP_PREFIX, data_byte, FILLER, FILLER};
			CMD_READ_LOCK:  frame = {OP_READ_LOCK, FILLER, FILLER, FILLER};
			CMD_READ_SIG:   frame = {OP_READ_SIG, addr_high, addr_low, FILLER};
			default: begin
				frame    = '0;
				frame_ok = 1'b0;
			end
		endcase
	end

endmodule

>>> design/isp_engine.sv
// ----------------------------------------------------------------------------
// isp_engine
// Frame shifter and erase wait counter. Computes the next state and the
// result for the item in the input register; commits both on step.
// ----------------------------------------------------------------------------
module isp_engine import isp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  isp_in_t           item_s1,
	input  logic [WAIT_W-1:0] erase_wait,
	input  logic              hold_rst,
	output isp_out_t          result
);

	logic [FRAME_W-1:0] frame_q, frame_n, new_frame;
	logic [BITS_W-1:0]  bits_q, bits_n;
	logic               phase_q, phase_n;
	logic [7:0]         shift_q, shift_n;
	logic               active_q, active_n;
	logic [WAIT_W-1:0]  wait_q, wait_n;
	logic [2:0]         cmd_q, cmd_n;
	logic               frame_ok;
	logic               done;
	logic               rejected;
	logic               shifting;

	isp_frame_build u_frame (
		.command   (item_s1.command),
		.addr_high (item_s1.addr_high),
		.addr_low  (item_s1.addr_low),
		.data_byte (item_s1.data_byte),
		.frame     (new_frame),
		.frame_ok  (frame_ok)
	);

	always_comb begin
		frame_n  = frame_q;
		bits_n   = bits_q;
		phase_n  = phase_q;
		shift_n  = shift_q;
		active_n = active_q;
		wait_n   = wait_q;
		cmd_n    = cmd_q;
		done     = 1'b0;
		rejected = 1'b0;
		if (item_s1.kind == KIND_START) begin
			if (active_q || !frame_ok) begin
				rejected = 1'b1;
			end else begin
				frame_n  = new_frame;
				bits_n   = BITS_W'(FRAME_W);
				phase_n  = 1'b0;
				active_n = 1'b1;
				wait_n   = '0;
				cmd_n    = item_s1.command;
			end
		end else if (active_q) begin
			if (bits_q != '0) begin
				if (!phase_q) begin
					// rising SCK: sample MISO
					phase_n = 1'b1;
					shift_n = {shift_q[6:0], item_s1.miso};
				end else begin
					// falling SCK: advance to the next bit
					phase_n = 1'b0;
					frame_n = {frame_q[FRAME_W-2:0], 1'b0};
					bits_n  = bits_q - BITS_W'(1);
					if (bits_q == BITS_W'(1)) begin
						if (cmd_q == CMD_ERASE && erase_wait != '0) begin
							wait_n = erase_wait;
						end else begin
							active_n = 1'b0;
							done     = 1'b1;
						end
					end
				end
			end else begin
				wait_n = wait_q - WAIT_W'(1);
				if (wait_q == WAIT_W'(1)) begin
					active_n = 1'b0;
					done     = 1'b1;
				end
			end
		end
	end

	assign shifting = active_n && (bits_n != '0);

	always_comb begin
		result.sck            = shifting & phase_n;
		result.mosi           = shifting & frame_n[FRAME_W-1];
		result.rst_res        = hold_rst;
		result.busy_res       = active_n;
		result.done_res       = done;
		result.read_byte      = done ? shift_n : 8'd0;
		result.start_rejected = rejected;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q  <= '0;
			bits_q   <= '0;
			phase_q  <= 1'b0;
			shift_q  <= '0;
			active_q <= 1'b0;
			wait_q   <= '0;
			cmd_q    <= '0;
		end else if (step) begin
			frame_q  <= frame_n;
			bits_q   <= bits_n;
			phase_q  <= phase_n;
			shift_q  <= shift_n;
			active_q <= active_n;
			wait_q   <= wait_n;
			cmd_q    <= cmd_n;
		end
	end

endmodule

>>> design/isp_serial_programmer.sv
// Path: an accepted item is held in the input register, then its result in
// the result register. Throughput: one item per cycle while result_stall
// does not hold the result register; the input register feeds the state
// update and the result register in a single pass. Reset: arst_n clears all
// control state and the frame; erase_wait_q returns to 520, hold_rst_q to 0.
// ----------------------------------------------------------------------------
// isp_serial_programmer
// Serial ISP master: builds command frames and shifts them out in SPI mode 0,
// one half SCK period per tick item, with an erase wait after chip erase.
// ----------------------------------------------------------------------------
module isp_serial_programmer import isp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  isp_in_t                item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output isp_out_t               result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	isp_in_t           item_s1;
	logic              valid_s1;
	logic              step;
	logic [WAIT_W-1:0] erase_wait_q;
	logic              hold_rst_q;
	isp_out_t          next_result;

	// move the held item into the result register when it is free
	assign step       = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !step;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_wait_q <= ERASE_WAIT_RST;
			hold_rst_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_ERASE_WAIT) begin
				erase_wait_q <= cfg_data[WAIT_W-1:0];
			end else if (cfg_index == CFG_HOLD_RST) begin
				hold_rst_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	isp_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item_s1    (item_s1),
		.erase_wait (erase_wait_q),
		.hold_rst   (hold_rst_q),
		.result     (next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (!result_valid || !result_stall) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result <= next_result;
		end
	end

endmodule

>>> sim/isp_serial_programmer_test.sv
// ----------------------------------------------------------------------------
// isp_serial_programmer_test
// Self-checking bench for the serial ISP master. A queue-fed driver offers
// start and tick items. The driver also runs a bit-accurate model of the frame
// shifter, and the monitor compares every result beat with the model, field by
// field. Each phase runs with its own erase wait and target reset level.
// ----------------------------------------------------------------------------
module isp_serial_programmer_test;
	import isp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0]             CMD_UNUSED  = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED  = 4'hF;
	localparam int                     MISO_LOW    = 0;
	localparam int                     MISO_HIGH   = 1;
	localparam int                     MISO_RANDOM = 2;
	localparam int                     IDLE_PCT    = 18;
	localparam int                     HOLD_AT     = 600;
	localparam int                     HOLD_CYCLES = 300;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_stall;
	isp_in_t                item         = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	isp_out_t               result;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	isp_in_t  pending_items[$];
	isp_out_t expected_pins[$];
	int       error_count  = 0;
	int       results_seen = 0;
	int       cycle_no     = 0;
	int       hold_left    = 0;
	bit       held         = 1'b0;

	// model copy of the programmer
	logic [WAIT_W-1:0]  wait_cfg;
	logic               hold_cfg;
	logic [FRAME_W-1:0] tx_frame;
	logic [BITS_W-1:0]  bits_to_go;
	logic               sck_high;
	logic [7:0]         rx_shift;
	logic               in_frame;
	logic [WAIT_W-1:0]  erase_left;
	logic [2:0]         running_cmd;

	isp_serial_programmer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
	end

	function automatic bit quiet_window();
		return cycle_no >= 100 && cycle_no < 600;
	endfunction

	function automatic isp_out_t advance_programmer(isp_in_t it);
		isp_out_t           r;
		logic [FRAME_W-1:0] f;
		logic               ok;
		logic               fin;
		logic               shifting;
		r = '0;
		f = '0;
		ok = 1'b1;
		fin = 1'b0;
		if (it.kind == KIND_START) begin
			case (it.command)
				CMD_ENABLE:     f = {OP_PREFIX, OP_ENABLE, FILLER, FILLER};
				CMD_ERASE:      f = {OP_PREFIX, OP_ERASE, FILLER, FILLER};
				CMD_READ_CODE:  f = {OP_READ_CODE, it.addr_high, it.addr_low, FILLER};
				CMD_WRITE_CODE: f = {OP_WRITE_CODE, it.addr_high, it.addr_low, it.data_byte};
				CMD_WRITE_LOCK: f = {OP_PREFIX, it.data_byte, FILLER, FILLER};
				CMD_READ_LOCK:  f = {OP_READ_LOCK, FILLER, FILLER, FILLER};
				CMD_READ_SIG:   f = {OP_READ_SIG, it.addr_high, it.addr_low, FILLER};
				default:        ok = 1'b0;
			endcase
			if (in_frame || !ok) begin
				r.start_rejected = 1'b1;
			end else begin
				tx_frame = f;
				bits_to_go = 6'd32;
				sck_high = 1'b0;
				in_frame = 1'b1;
				erase_left = '0;
				running_cmd = it.command;
			end
		end else if (in_frame) begin
			if (bits_to_go != 0) begin
				if (!sck_high) begin
					// rising SCK: sample MISO
					sck_high = 1'b1;
					rx_shift = {rx_shift[6:0], it.miso};
				end else begin
					sck_high = 1'b0;
					tx_frame = tx_frame << 1;
					bits_to_go = bits_to_go - 6'd1;
					if (bits_to_go == 0) begin
						if (running_cmd == CMD_ERASE && wait_cfg != 0) begin
							erase_left = wait_cfg;
						end else begin
							in_frame = 1'b0;
							fin = 1'b1;
						end
					end
				end
			end else begin
				erase_left = erase_left - 1'b1;
				if (erase_left == 0) begin
					in_frame = 1'b0;
					fin = 1'b1;
				end
			end
		end
		shifting = in_frame && bits_to_go != 0;
		r.sck = shifting ? sck_high : 1'b0;
		r.mosi = shifting ? tx_frame[FRAME_W-1] : 1'b0;
		r.rst_res = hold_cfg;
		r.busy_res = in_frame;
		r.done_res = fin;
		r.read_byte = fin ? rx_shift : 8'h00;
		return r;
	endfunction

	// driver: hold a stalled beat, otherwise advance or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				expected_pins.push_back(advance_programmer(item));
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 &&
				    (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_pin(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// monitor: compare beats, stall at random, one long hold-off
	always @(posedge clk) begin
		isp_out_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_pins.size() == 0) begin
					$error("result beat with nothing expected: %h", result);
					error_count++;
				end else begin
					want = expected_pins.pop_front();
					check_pin("sck", want.sck, result.sck);
					check_pin("mosi", want.mosi, result.mosi);
					check_pin("rst_res", want.rst_res, result.rst_res);
					check_pin("busy_res", want.busy_res, result.busy_res);
					check_pin("done_res", want.done_res, result.done_res);
					check_pin("read_byte", want.read_byte, result.read_byte);
					check_pin("start_rejected", want.start_rejected, result.start_rejected);
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (!held && results_seen >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !quiet_window() && $urandom_range(0, 99) < IDLE_PCT;
			end
		end
	end

	task automatic push_item(input logic kind, input logic [2:0] cmd, input logic [7:0] ah,
	                         input logic [7:0] al, input logic [7:0] d, input logic miso);
		isp_in_t it;
		it.kind = kind;
		it.command = cmd;
		it.addr_high = ah;
		it.addr_low = al;
		it.data_byte = d;
		it.miso = miso;
		pending_items.push_back(it);
	endtask

	task automatic push_start(input logic [2:0] cmd, input logic [7:0] ah, input logic [7:0] al,
	                          input logic [7:0] d);
		push_item(KIND_START, cmd, ah, al, d, 1'($urandom_range(0, 1)));
	endtask

	task automatic push_tick(input logic miso);
		push_item(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
		          8'($urandom), miso);
	endtask

	// one command: start, 64 half periods, then the erase wait if any
	task automatic queue_command(input logic [2:0] cmd, input logic [7:0] ah, input logic [7:0] al,
	                             input logic [7:0] d, input int miso_sel, input bit noisy,
	                             input logic [WAIT_W-1:0] wait_ticks);
		int   total;
		logic level;
		total = 64 + ((cmd == CMD_ERASE) ? int'(wait_ticks) : 0);
		push_start(cmd, ah, al, d);
		for (int i = 0; i < total; i++) begin
			if (noisy && (i == 5 || $urandom_range(0, 29) == 0))
				push_start(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 8'($urandom));
			level = (miso_sel == MISO_RANDOM) ? 1'($urandom_range(0, 1)) : (miso_sel == MISO_HIGH);
			push_tick(level);
		end
	endtask

	task automatic queue_random_phase(input logic [WAIT_W-1:0] wait_ticks, input bit allow_erase);
		int         count;
		int         pick;
		logic [2:0] cmd;
		count = 0;
		if (allow_erase) begin
			queue_command(CMD_ERASE, 8'($urandom), 8'($urandom), 8'($urandom), MISO_RANDOM,
			              1'b0, wait_ticks);
			count += 65 + int'(wait_ticks);
		end
		while (count < 65) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				if ($urandom_range(0, 1))
					push_tick(1'($urandom_range(0, 1)));
				else
					push_start(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				cmd = 3'($urandom_range(0, 6));
				if (!allow_erase && cmd == CMD_ERASE)
					cmd = CMD_READ_SIG;
				queue_command(cmd, 8'($urandom), 8'($urandom), 8'($urandom), MISO_RANDOM,
				              pick < 4, wait_ticks);
				count += 65 + ((cmd == CMD_ERASE) ? int'(wait_ticks) : 0);
			end
		end
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
	                              input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == CFG_ERASE_WAIT)
			wait_cfg = value[WAIT_W-1:0];
		else if (index == CFG_HOLD_RST)
			hold_cfg = value[0];
	endtask

	// wait until every beat is accepted and answered, then let the pipe settle
	task automatic drain();
		while (pending_items.size() != 0 || item_valid || expected_pins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [WAIT_W-1:0] w;
		wait_cfg = ERASE_WAIT_RST;
		hold_cfg = 1'b0;
		tx_frame = '0;
		bits_to_go = '0;
		sck_high = 1'b0;
		rx_shift = '0;
		in_frame = 1'b0;
		erase_left = '0;
		running_cmd = '0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: idle ticks, unused code, every command at field extremes
		push_item(KIND_TICK, CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		push_item(KIND_TICK, CMD_ENABLE, 8'h00, 8'h00, 8'h00, 1'b0);
		push_item(KIND_START, CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		queue_command(CMD_ENABLE, 8'h00, 8'h00, 8'h00, MISO_HIGH, 1'b0, wait_cfg);
		queue_command(CMD_READ_CODE, 8'hFF, 8'h00, 8'h00, MISO_RANDOM, 1'b1, wait_cfg);
		queue_command(CMD_WRITE_CODE, 8'h00, 8'hFF, 8'hFF, MISO_LOW, 1'b0, wait_cfg);
		queue_command(CMD_WRITE_LOCK, 8'hFF, 8'hFF, 8'h00, MISO_RANDOM, 1'b0, wait_cfg);
		queue_command(CMD_READ_LOCK, 8'h00, 8'h00, 8'hFF, MISO_HIGH, 1'b0, wait_cfg);
		queue_command(CMD_READ_SIG, 8'hFF, 8'hFF, 8'h00, MISO_RANDOM, 1'b0, wait_cfg);
		queue_command(CMD_ERASE, 8'h00, 8'h00, 8'h00, MISO_RANDOM, 1'b1, wait_cfg);
		push_item(KIND_TICK, CMD_ERASE, 8'h55, 8'hAA, 8'h55, 1'b1);
		drain();

		write_register(CFG_ERASE_WAIT, 20'h00000);
		write_register(CFG_HOLD_RST, 20'hFFFFF);
		queue_random_phase(20'h00000, 1'b1);
		drain();

		write_register(CFG_ERASE_WAIT, 20'h00001);
		write_register(CFG_HOLD_RST, 20'hFFFFE);
		write_register(CFG_UNUSED, 20'($urandom));
		queue_random_phase(20'h00001, 1'b1);
		drain();

		// longest wait: keep erase out so the run stays short
		write_register(CFG_ERASE_WAIT, 20'hFFFFF);
		write_register(CFG_HOLD_RST, 20'h00001);
		queue_random_phase(20'hFFFFF, 1'b0);
		drain();

		w = 20'($urandom_range(2, 40));
		write_register(CFG_ERASE_WAIT, w);
		write_register(CFG_HOLD_RST, 20'($urandom_range(0, 1)));
		queue_random_phase(w, 1'b1);
		drain();

		write_register(CFG_ERASE_WAIT, 20'h00003);
		write_register(CFG_HOLD_RST, 20'h00000);
		queue_random_phase(20'h00003, 1'b1);
		drain();

		if (expected_pins.size() != 0) begin
			$error("%0d result beats never arrived", expected_pins.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
design/isp_pkg.sv
design/isp_frame_build.sv
design/isp_engine.sv
design/isp_serial_programmer.sv
sim/isp_serial_programmer_test.sv
